// ----- design/cht_pkg.sv -----
// Package for the cuckoo hash table core: sizes, slot layout, codes, states.
// Used by cuckoo_hash_table_core; depends on nothing.
`default_nettype none

package cht_pkg;

  // Table geometry
  localparam int TABLE_BITS = 10;
  localparam int NUM_HASHES = 3;
  localparam int SLOTS      = 1 << TABLE_BITS;
  localparam int CNT_W      = TABLE_BITS + 1;

  // Noise ROM: 2048 words per hash level, eight byte lanes of 256 words
  localparam int LVL_W      = (NUM_HASHES > 2) ? 2 : 1;
  localparam int ROM_WORDS  = NUM_HASHES * 2048;
  localparam int ROM_AW     = LVL_W + 11;

  // Insert limits
  localparam int MAX_KICKS    = 5 * TABLE_BITS;
  localparam int KICK_W       = $clog2(MAX_KICKS + 1);
  localparam int MAX_ATTEMPTS = 5;
  localparam int ATT_W        = 3;
  localparam int LOAD_LIMIT   = 4 * SLOTS;
  localparam int LOAD_W       = CNT_W + 3;

  // Mixing and reseed constants
  localparam logic [63:0] SPLIT_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX1_MUL    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX2_MUL    = 64'h94D049BB133111EB;
  localparam logic [63:0] LCG_MUL     = 64'h5851F42D4C957F2D;
  localparam logic [63:0] LCG_INC     = 64'h14057B7EF767814F;

  // Slot word: flags bit 0 present, bits 2..1 hash level
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
    logic [2:0]  flags;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MUL_MIX1 = 2'd0,
    MUL_MIX2 = 2'd1,
    MUL_LCG  = 2'd2
  } mul_sel_t;

  // Who called the placement loop
  typedef enum logic [1:0] {
    CTX_INSERT  = 2'd0,
    CTX_REBUILD = 2'd1,
    CTX_REHASH  = 2'd2
  } ctx_t;

  typedef enum logic [4:0] {
    ST_INIT_MIX1,
    ST_INIT_W1,
    ST_INIT_W2,
    ST_CLEAR,
    ST_IDLE,
    ST_DONE,
    ST_LK_HASH,
    ST_LK_HWAIT,
    ST_LK_CHK,
    ST_PL_START,
    ST_PL_HWAIT,
    ST_PL_RD,
    ST_RB_CHECK,
    ST_RB_MUL,
    ST_RH_RD,
    ST_RH_CHK,
    ST_RH_HWAIT,
    ST_RH_NEXT
  } state_t;

  // 16-bit slice of a multiplier constant for the serial multiplier
  function automatic logic [15:0] mul_chunk(mul_sel_t sel, logic [1:0] idx);
    logic [63:0] c;
    case (sel)
      MUL_MIX1: c = MIX1_MUL;
      MUL_MIX2: c = MIX2_MUL;
      default:  c = LCG_MUL;
    endcase
    return c[{idx, 4'b0000} +: 16];
  endfunction

endpackage

`default_nettype wire

// ----- design/cht_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/cuckoo_hash_table_core.sv -----
// Cuckoo hash table core: sequencer, tabulation hash unit, serial multiplier.
// Depends on cht_pkg and cht_ram (slot table and noise ROM).
//
//   channel | signals                         | direction
//   in      | in_valid in_ready mode key value | request into the core
//   out     | out_valid out_ready found        | result out of the core
//           | read_value status                |
//
// After reset the noise ROM is filled, one word from two products of the serial
// 64x16 multiplier, then a pass over every slot clears the flags. One hash makes
// eight reads of the single ROM port. A lookup or delete hashes and reads one
// slot per level tried; an insert does so for its first slot and per further
// kick. A rebuild rehashes the table: it reads every slot, hashes each present
// entry anew and places again the entries that move.
// A delete that empties the table runs the clearing pass before its result.
// The input is taken while a result waits in the output register.
`default_nettype none

module cuckoo_hash_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [63:0] key,
  input  wire logic [63:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output logic [63:0]      read_value,
  output logic             status
);

  localparam logic [cht_pkg::TABLE_BITS-1:0] LAST_SLOT = '1;

  cht_pkg::state_t state, state_next;

  // sequencer registers
  cht_pkg::op_t                  op_mode;
  cht_pkg::ctx_t                 ctx;
  logic [63:0]                   e_key;
  logic [63:0]                   e_val;
  logic [cht_pkg::LVL_W-1:0]     e_lvl;
  logic [cht_pkg::LVL_W-1:0]     lk_lvl;
  logic [cht_pkg::KICK_W-1:0]    kcnt;
  logic [cht_pkg::ATT_W-1:0]     attempts;
  logic [cht_pkg::TABLE_BITS-1:0] tidx;
  logic [cht_pkg::TABLE_BITS-1:0] ridx;
  logic [cht_pkg::TABLE_BITS-1:0] cidx;
  logic                          rh_drop;
  logic                          clr_to_done;
  logic [63:0]                   seed;
  logic [cht_pkg::CNT_W-1:0]     count;
  logic [63:0]                   split_s;
  logic [cht_pkg::ROM_AW-1:0]    rom_n;
  logic                          res_found;
  logic [63:0]                   res_rv;
  logic                          res_status;

  // hash unit
  logic                           hash_start;
  logic [63:0]                    hash_key;
  logic [cht_pkg::LVL_W-1:0]      hash_lvl;
  logic                           h_busy;
  logic                           h_done;
  logic [3:0]                     h_cnt;
  logic [63:0]                    h_x;
  logic [cht_pkg::LVL_W-1:0]      h_lvl;
  logic [cht_pkg::TABLE_BITS-1:0] h_acc;

  // serial multiplier
  logic              mul_start;
  logic [63:0]       mul_a;
  cht_pkg::mul_sel_t mul_sel;
  logic              m_busy;
  logic              m_done;
  logic [1:0]        m_cnt;
  logic [63:0]       m_a;
  cht_pkg::mul_sel_t m_sel;
  logic [63:0]       m_acc;
  logic [63:0]       m_prod;

  // memories
  logic                           t_we;
  logic [cht_pkg::TABLE_BITS-1:0] t_waddr;
  cht_pkg::slot_t                 t_wdata;
  logic [cht_pkg::TABLE_BITS-1:0] t_raddr;
  cht_pkg::slot_t                 t_rdata;
  logic                           rom_we;
  logic [cht_pkg::ROM_AW-1:0]     rom_raddr;
  logic [15:0]                    rom_wdata;
  logic [15:0]                    rom_q;

  // decoded values
  logic                      q_present;
  logic [1:0]                q_lvl2;
  logic [1:0]                q_next2;
  logic [cht_pkg::LVL_W-1:0] q_next;
  logic                      pl_fail;
  logic                      lk_hit;
  logic [cht_pkg::LOAD_W-1:0] five_cnt;
  logic                      load_full;
  logic                      out_load;

  cht_ram #(.WIDTH(cht_pkg::SLOT_W), .DEPTH(cht_pkg::SLOTS)) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  cht_ram #(.WIDTH(16), .DEPTH(cht_pkg::ROM_WORDS)) u_noise (
    .clk   (clk),
    .we    (rom_we),
    .waddr (rom_n),
    .wdata (rom_wdata),
    .raddr (rom_raddr),
    .rdata (rom_q)
  );

  // slot decode
  assign q_present = t_rdata.flags[0];
  assign q_lvl2    = t_rdata.flags[2:1];
  assign q_next2   = (q_lvl2 >= 2'(cht_pkg::NUM_HASHES - 1)) ? 2'd0 : q_lvl2 + 2'd1;
  assign q_next    = cht_pkg::LVL_W'(q_next2);
  assign pl_fail   = q_present && (kcnt == cht_pkg::KICK_W'(cht_pkg::MAX_KICKS - 1));
  assign lk_hit    = q_present && (t_rdata.key == e_key);
  assign five_cnt  = {1'b0, count, 2'b00} + cht_pkg::LOAD_W'(count);
  assign load_full = (five_cnt >= cht_pkg::LOAD_W'(cht_pkg::LOAD_LIMIT)) ||
                     (attempts > cht_pkg::ATT_W'(cht_pkg::MAX_ATTEMPTS));
  assign rom_wdata = m_acc[15:0] ^ m_acc[46:31];
  assign rom_raddr = {h_lvl, h_cnt[2:0], h_x[7:0]};

  // tabulation hash: one ROM read per key byte, data in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      h_busy <= 1'b0;
      h_done <= 1'b0;
    end else begin
      h_done <= 1'b0;
      if (hash_start) begin
        h_busy <= 1'b1;
        h_cnt  <= 4'd0;
        h_x    <= seed ^ hash_key;
        h_lvl  <= hash_lvl;
        h_acc  <= '0;
      end else if (h_busy) begin
        h_cnt <= h_cnt + 4'd1;
        h_x   <= h_x >> 8;
        if (h_cnt != 4'd0) begin
          h_acc <= h_acc ^ rom_q[cht_pkg::TABLE_BITS-1:0];
        end
        if (h_cnt == 4'd8) begin
          h_busy <= 1'b0;
          h_done <= 1'b1;
        end
      end
    end
  end

  // serial multiplier mod 2^64, 16 bits of the constant per cycle
  assign m_prod = m_a * {48'd0, cht_pkg::mul_chunk(m_sel, m_cnt)};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_busy <= 1'b0;
      m_done <= 1'b0;
    end else begin
      m_done <= 1'b0;
      if (mul_start) begin
        m_busy <= 1'b1;
        m_cnt  <= 2'd0;
        m_a    <= mul_a;
        m_sel  <= mul_sel;
        m_acc  <= '0;
      end else if (m_busy) begin
        m_cnt <= m_cnt + 2'd1;
        m_acc <= m_acc + (m_prod << {m_cnt, 4'b0000});
        if (m_cnt == 2'd3) begin
          m_busy <= 1'b0;
          m_done <= 1'b1;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cht_pkg::ST_INIT_MIX1: state_next = cht_pkg::ST_INIT_W1;
      cht_pkg::ST_INIT_W1:   if (m_done) state_next = cht_pkg::ST_INIT_W2;
      cht_pkg::ST_INIT_W2: begin
        if (m_done) begin
          state_next = (rom_n == cht_pkg::ROM_AW'(cht_pkg::ROM_WORDS - 1)) ?
                       cht_pkg::ST_CLEAR : cht_pkg::ST_INIT_MIX1;
        end
      end
      cht_pkg::ST_CLEAR: begin
        if (cidx == LAST_SLOT) begin
          state_next = clr_to_done ? cht_pkg::ST_DONE : cht_pkg::ST_IDLE;
        end
      end
      cht_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (cht_pkg::op_t'(mode))
            cht_pkg::OP_INSERT: state_next = cht_pkg::ST_PL_START;
            cht_pkg::OP_LOOKUP: state_next = cht_pkg::ST_LK_HASH;
            cht_pkg::OP_DELETE: state_next = cht_pkg::ST_LK_HASH;
            default:            state_next = cht_pkg::ST_DONE;
          endcase
        end
      end
      cht_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_next = cht_pkg::ST_IDLE;
      end
      cht_pkg::ST_LK_HASH:  state_next = cht_pkg::ST_LK_HWAIT;
      cht_pkg::ST_LK_HWAIT: if (h_done) state_next = cht_pkg::ST_LK_CHK;
      cht_pkg::ST_LK_CHK: begin
        priority if (lk_hit) begin
          state_next = (op_mode == cht_pkg::OP_DELETE && count == cht_pkg::CNT_W'(1)) ?
                       cht_pkg::ST_CLEAR : cht_pkg::ST_DONE;
        end else if (lk_lvl == cht_pkg::LVL_W'(cht_pkg::NUM_HASHES - 1)) begin
          state_next = cht_pkg::ST_DONE;
        end else begin
          state_next = cht_pkg::ST_LK_HASH;
        end
      end
      cht_pkg::ST_PL_START: state_next = cht_pkg::ST_PL_HWAIT;
      cht_pkg::ST_PL_HWAIT: if (h_done) state_next = cht_pkg::ST_PL_RD;
      cht_pkg::ST_PL_RD: begin
        priority if (!q_present) begin
          case (ctx)
            cht_pkg::CTX_INSERT:  state_next = cht_pkg::ST_DONE;
            cht_pkg::CTX_REBUILD: state_next = cht_pkg::ST_RH_RD;
            default:              state_next = cht_pkg::ST_RH_NEXT;
          endcase
        end else if (pl_fail) begin
          state_next = (ctx == cht_pkg::CTX_REHASH && rh_drop) ?
                       cht_pkg::ST_RH_NEXT : cht_pkg::ST_RB_CHECK;
        end else begin
          state_next = cht_pkg::ST_PL_HWAIT;
        end
      end
      cht_pkg::ST_RB_CHECK: state_next = load_full ? cht_pkg::ST_RH_RD : cht_pkg::ST_RB_MUL;
      cht_pkg::ST_RB_MUL:   if (m_done) state_next = cht_pkg::ST_PL_START;
      cht_pkg::ST_RH_RD:    state_next = cht_pkg::ST_RH_CHK;
      cht_pkg::ST_RH_CHK:   state_next = q_present ? cht_pkg::ST_RH_HWAIT : cht_pkg::ST_RH_NEXT;
      cht_pkg::ST_RH_HWAIT: begin
        if (h_done) begin
          state_next = (h_acc == ridx) ? cht_pkg::ST_RH_NEXT : cht_pkg::ST_PL_START;
        end
      end
      cht_pkg::ST_RH_NEXT: begin
        state_next = (ridx == LAST_SLOT) ? cht_pkg::ST_DONE : cht_pkg::ST_RH_RD;
      end
      default: state_next = cht_pkg::ST_IDLE;
    endcase
  end

  // control outputs to memories and units
  always_comb begin
    hash_start = 1'b0;
    hash_key   = e_key;
    hash_lvl   = '0;
    mul_start  = 1'b0;
    mul_a      = seed;
    mul_sel    = cht_pkg::MUL_LCG;
    t_we       = 1'b0;
    t_waddr    = tidx;
    t_wdata    = '0;
    t_raddr    = tidx;
    rom_we     = 1'b0;
    in_ready   = 1'b0;
    case (state)
      cht_pkg::ST_INIT_MIX1: begin
        mul_start = 1'b1;
        mul_a     = split_s ^ (split_s >> 30);
        mul_sel   = cht_pkg::MUL_MIX1;
      end
      cht_pkg::ST_INIT_W1: begin
        mul_start = m_done;
        mul_a     = m_acc ^ (m_acc >> 27);
        mul_sel   = cht_pkg::MUL_MIX2;
      end
      cht_pkg::ST_INIT_W2: rom_we = m_done;
      cht_pkg::ST_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = cidx;
      end
      cht_pkg::ST_IDLE: in_ready = 1'b1;
      cht_pkg::ST_LK_HASH: begin
        hash_start = 1'b1;
        hash_lvl   = lk_lvl;
      end
      cht_pkg::ST_LK_HWAIT, cht_pkg::ST_PL_HWAIT: t_raddr = h_acc;
      cht_pkg::ST_LK_CHK: begin
        t_we    = lk_hit && (op_mode == cht_pkg::OP_DELETE);
        t_wdata = '{key: t_rdata.key, value: t_rdata.value, flags: 3'b000};
      end
      cht_pkg::ST_PL_START: hash_start = 1'b1;
      cht_pkg::ST_PL_RD: begin
        t_we       = 1'b1;
        t_wdata    = '{key: e_key, value: e_val, flags: {2'(e_lvl), 1'b1}};
        hash_start = q_present && !pl_fail;
        hash_key   = t_rdata.key;
        hash_lvl   = q_next;
      end
      cht_pkg::ST_RB_CHECK: mul_start = !load_full;
      cht_pkg::ST_RH_RD:    t_raddr = ridx;
      cht_pkg::ST_RH_CHK: begin
        hash_start = q_present;
        hash_key   = t_rdata.key;
        hash_lvl   = cht_pkg::LVL_W'(q_lvl2);
      end
      cht_pkg::ST_RH_HWAIT: begin
        t_we    = h_done && (h_acc != ridx);
        t_waddr = ridx;
        t_wdata = '{key: e_key, value: e_val, flags: {2'(e_lvl), 1'b0}};
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cht_pkg::ST_INIT_MIX1;
      seed        <= '0;
      count       <= '0;
      split_s     <= cht_pkg::SPLIT_GAMMA;
      rom_n       <= '0;
      cidx        <= '0;
      clr_to_done <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        cht_pkg::ST_INIT_W2: begin
          if (m_done) begin
            rom_n   <= rom_n + cht_pkg::ROM_AW'(1);
            split_s <= split_s + cht_pkg::SPLIT_GAMMA;
            cidx    <= '0;
          end
        end
        cht_pkg::ST_CLEAR: cidx <= cidx + cht_pkg::TABLE_BITS'(1);
        cht_pkg::ST_IDLE: begin
          if (in_valid) begin
            op_mode     <= cht_pkg::op_t'(mode);
            e_key       <= key;
            e_val       <= value;
            lk_lvl      <= '0;
            ctx         <= cht_pkg::CTX_INSERT;
            clr_to_done <= 1'b0;
            res_found   <= 1'b0;
            res_rv      <= '0;
            res_status  <= 1'b0;
            if (cht_pkg::op_t'(mode) == cht_pkg::OP_INSERT) begin
              count <= count + cht_pkg::CNT_W'(1);
            end
          end
        end
        cht_pkg::ST_LK_HWAIT: if (h_done) tidx <= h_acc;
        cht_pkg::ST_LK_CHK: begin
          if (lk_hit) begin
            res_found <= 1'b1;
            if (op_mode == cht_pkg::OP_LOOKUP) res_rv <= t_rdata.value;
            if (op_mode == cht_pkg::OP_DELETE) begin
              count <= count - cht_pkg::CNT_W'(1);
              if (count == cht_pkg::CNT_W'(1)) begin
                seed        <= '0;
                cidx        <= '0;
                clr_to_done <= 1'b1;
              end
            end
          end else begin
            lk_lvl <= lk_lvl + cht_pkg::LVL_W'(1);
          end
        end
        cht_pkg::ST_PL_START: begin
          e_lvl <= '0;
          kcnt  <= '0;
        end
        cht_pkg::ST_PL_HWAIT: if (h_done) tidx <= h_acc;
        cht_pkg::ST_PL_RD: begin
          if (!q_present) begin
            // rebuild placed its entry: start a fresh rehash pass
            if (ctx == cht_pkg::CTX_REBUILD) begin
              ridx    <= '0;
              rh_drop <= 1'b0;
            end
          end else begin
            e_key <= t_rdata.key;
            e_val <= t_rdata.value;
            e_lvl <= q_next;
            kcnt  <= kcnt + cht_pkg::KICK_W'(1);
            if (pl_fail) begin
              if (ctx == cht_pkg::CTX_INSERT) attempts <= '0;
              if (ctx == cht_pkg::CTX_REHASH && rh_drop && count != '0) begin
                count <= count - cht_pkg::CNT_W'(1);
              end
            end
          end
        end
        cht_pkg::ST_RB_CHECK: begin
          if (load_full) begin
            if (count != '0) count <= count - cht_pkg::CNT_W'(1);
            res_status <= 1'b1;
            rh_drop    <= 1'b1;
            ridx       <= '0;
          end else begin
            attempts <= attempts + cht_pkg::ATT_W'(1);
          end
        end
        cht_pkg::ST_RB_MUL: begin
          if (m_done) begin
            seed <= m_acc + cht_pkg::LCG_INC;
            ctx  <= cht_pkg::CTX_REBUILD;
          end
        end
        cht_pkg::ST_RH_CHK: begin
          e_key <= t_rdata.key;
          e_val <= t_rdata.value;
          e_lvl <= cht_pkg::LVL_W'(q_lvl2);
        end
        cht_pkg::ST_RH_HWAIT: if (h_done) ctx <= cht_pkg::CTX_REHASH;
        cht_pkg::ST_RH_NEXT:  ridx <= ridx + cht_pkg::TABLE_BITS'(1);
        default: ;
      endcase
    end
  end

  // output register
  assign out_load = (state == cht_pkg::ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found      <= res_found;
      read_value <= res_rv;
      status     <= res_status;
    end
  end

`ifndef SYNTHESIS
  // a new hash never lands on a running one
  a_hash_idle: assert property (@(posedge clk) disable iff (rst) hash_start |-> !h_busy)
    else $error("hash started while busy");
  // a new product never lands on a running one
  a_mul_idle: assert property (@(posedge clk) disable iff (rst) mul_start |-> !m_busy)
    else $error("multiply started while busy");
  // both units are quiet once a result is ready
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == cht_pkg::ST_DONE) |-> (!h_busy && !m_busy))
    else $error("unit busy at result");
  // occupancy stays within one over the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= cht_pkg::CNT_W'(cht_pkg::SLOTS + 1))
    else $error("entry count out of range");
`endif

endmodule

`default_nettype wire
